// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg: shared definitions of the signed binary to decimal ASCII block
// Widths, character codes, the sequencer state type and the control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

    // Width of the signed input value.
    localparam int VALUE_BITS = 32;

    // Number of decimal digits of 2^(VALUE_BITS-1), the largest magnitude.
    function automatic int calc_digits(input int bits);
        longint unsigned v;
        int              n;
        v = 64'd1 << (bits - 1);
        n = 0;
        while (v != 64'd0) begin
            v = v / 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = calc_digits(VALUE_BITS);
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // Commands from the sequencer to the digit shift register.
    typedef struct packed {
        logic load;
        logic dabble;
        logic dig_shift;
    } t_dab_ctrl;

endpackage

`default_nettype wire

// ===== rtl/sbda_dabble.sv =====
// ----------------------------------------------------------------------------
// sbda_dabble: bit-serial binary to BCD shift register
// Loads the magnitude, shifts it into a BCD register one bit per cycle with
// add-3 correction, then hands digits out most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_dabble
    import sbda_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_dab_ctrl             i_ctrl,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic      [3:0]            o_top_digit
);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [VALUE_BITS-1:0] w_mag;
    logic [BCD_W-1:0]      w_adj;

    // Magnitude as an unsigned value; the most negative input maps to 2^(N-1).
    assign w_mag = i_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - i_value) : i_value;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? (r_bcd[i*4 +: 4] + 4'd3)
                                                        : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= w_mag;
            r_bcd <= '0;
        end else if (i_ctrl.dabble) begin
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_ctrl.dig_shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/sbda_out_stage.sv =====
// ----------------------------------------------------------------------------
// sbda_out_stage: output register of the character stream
// Holds one character request until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_out_stage
    import sbda_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [M_TDATA_W-1:0] i_char,
    input  wire logic                 i_last,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output logic      [M_TDATA_W-1:0] o_char,
    output logic                      o_last,
    output logic                      o_free
);

    logic                 r_valid;
    logic [M_TDATA_W-1:0] r_char;
    logic                 r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    // The slot can take a new character when empty or emptied this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one signed value per request into its decimal characters.
// ----------------------------------------------------------------------------
// Each input request carries one signed two's complement value of VALUE_BITS
// bits in the low bits of i_s_tdata; any padding bits above it are ignored.
// The block answers with one output request per character, most significant
// first: a '-' for negative values, then the digits without leading zeros
// (zero gives the single character '0'), with o_m_tlast high on the last
// digit. The most negative value is converted exactly. One value is worked on
// at a time. The bit-serial binary to BCD shift register sets the pace of a
// value: it is accepted, its VALUE_BITS bits are shifted in, each leading
// zero is dropped, the first digit to send is found, and then a '-' for a
// negative value and each digit are written into the output register in
// turn. A finished character waits in that register, so downstream stalls
// only slow the character phase.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input stream. i_s_tdata bits from low: value (VALUE_BITS), zero padding.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // Output stream. o_m_tdata bits from low: char_code (8). o_m_tlast: last_char.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata,
    output logic                      o_m_tlast
);

    t_state                r_state;
    t_state                n_state;
    logic                  r_neg;
    logic                  n_neg;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [BIT_CNT_W-1:0]  n_bit_cnt;
    logic [DIG_CNT_W-1:0]  r_dig_cnt;
    logic [DIG_CNT_W-1:0]  n_dig_cnt;

    t_dab_ctrl             w_ctrl;
    logic [3:0]            w_top_digit;
    logic                  w_accept;
    logic                  w_out_load;
    logic [M_TDATA_W-1:0]  w_out_char;
    logic                  w_out_last;
    logic                  w_out_free;
    logic                  w_skip_zero;
    logic                  w_last_digit;

    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_last_digit = (r_dig_cnt == DIG_CNT_W'(1));
    // A leading zero is dropped unless it is the only digit left.
    assign w_skip_zero  = (w_top_digit == 4'd0) && !w_last_digit;

    sbda_dabble u_dabble (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_value     (i_s_tdata[VALUE_BITS-1:0]),
        .o_top_digit (w_top_digit)
    );

    sbda_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_char  (w_out_char),
        .i_last  (w_out_last),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_char  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_free  (w_out_free)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_CONV;
            end
            S_CONV: begin
                if (r_bit_cnt == BIT_CNT_W'(1)) n_state = S_SKIP;
            end
            S_SKIP: begin
                if (!w_skip_zero) n_state = r_neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (w_out_free) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free && w_last_digit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and counters.
    always_comb begin
        o_s_tready = 1'b0;
        w_ctrl     = '0;
        w_out_load = 1'b0;
        w_out_char = CHAR_ZERO + {4'd0, w_top_digit};
        w_out_last = w_last_digit;
        n_neg      = r_neg;
        n_bit_cnt  = r_bit_cnt;
        n_dig_cnt  = r_dig_cnt;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    w_ctrl.load = 1'b1;
                    n_neg       = i_s_tdata[VALUE_BITS-1];
                    n_bit_cnt   = BIT_CNT_W'(VALUE_BITS);
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_bit_cnt     = r_bit_cnt - BIT_CNT_W'(1);
                n_dig_cnt     = DIG_CNT_W'(NUM_DIGITS);
            end
            S_SKIP: begin
                if (w_skip_zero) begin
                    w_ctrl.dig_shift = 1'b1;
                    n_dig_cnt        = r_dig_cnt - DIG_CNT_W'(1);
                end
            end
            S_SIGN: begin
                w_out_char = CHAR_MINUS;
                w_out_last = 1'b0;
                w_out_load = w_out_free;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load       = 1'b1;
                    w_ctrl.dig_shift = 1'b1;
                    n_dig_cnt        = r_dig_cnt - DIG_CNT_W'(1);
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept || (r_state != S_IDLE)) begin
            r_neg     <= n_neg;
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbda_checker.sv =====
// ----------------------------------------------------------------------------
// sbda_checker: port-level checks of the decimal ASCII converter
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbda_checker
    import sbda_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic                 o_m_tlast
);

    logic                 w_m_stall;
    logic [M_TDATA_W+1:0] w_m_word;
    logic                 w_m_legal;
    logic                 w_m_sign;
    logic                 w_s_accept;

    assign w_m_stall  = o_m_tvalid && !i_m_tready;
    assign w_m_word   = {o_m_tvalid, o_m_tlast, o_m_tdata};
    assign w_m_legal  = (o_m_tdata == CHAR_MINUS) ||
                        (o_m_tdata inside {[CHAR_ZERO:CHAR_ZERO + 8'd9]});
    assign w_m_sign   = o_m_tvalid && (o_m_tdata == CHAR_MINUS);
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // A stalled character request stays valid and keeps its contents.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, w_m_stall |=> $stable(w_m_word), "stall broken")

    // Only a minus sign or a decimal digit is ever sent.
    `ASSERT_CLK_RST(a_char_legal, i_clk, i_rst_n, o_m_tvalid |-> w_m_legal, "illegal character")

    // The sign is never the last character of a number.
    `ASSERT_CLK_RST(a_sign_not_last, i_clk, i_rst_n, w_m_sign |-> !o_m_tlast, "sign is last")

    // Once a value is taken, the input port is no longer ready for the next one.
    `ASSERT_CLK_RST(a_one_value, i_clk, i_rst_n, w_s_accept |=> !o_s_tready, "taken while busy")

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
